/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset disable.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `ASSERT_AT(label, clk, rst, cond, msg)

`endif

/* design/nmgga_pkg.sv */
package nmgga_pkg;

   // Sentence limits
   localparam int LINE_FIELD_LIMIT = 20;
   localparam int FRACTION_DIGITS  = 5;
   localparam int COMMA_W          = $clog2(LINE_FIELD_LIMIT);

   // Queue depth between front and back, and on the result side
   localparam int QUEUE_DEPTH = 4;

   // Minutes accumulator: up to 100 whole minutes plus the fraction digits
   localparam int MS_W  = $clog2(101 * 10**FRACTION_DIGITS);
   localparam int MR_W  = MS_W + 20;
   localparam int DEG_W = 30;
   localparam int X_W   = 27;

   // Exact divide by 60 for values below 2**27: (x * RECIP_60) >> RECIP_SHIFT
   localparam int          RECIP_W     = 28;
   localparam int          RECIP_SHIFT = 33;
   localparam logic [RECIP_W-1:0] RECIP_60 = 28'd143165577;

   // Result widths
   localparam int LAT_W = 28;
   localparam int LON_W = 31;
   localparam int SAT_W = 7;
   localparam int MAG_W = 31;
   localparam logic [MAG_W-1:0] LAT_LIMIT = 31'd101666666;

   // Characters
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_W      = 8'h57;

   // One coordinate as the front hands it over
   typedef struct packed {
      logic            len_ok;
      logic            three_mode;
      logic [6:0]      two;
      logic [9:0]      three;
      logic [MS_W-1:0] scaled;
      logic [2:0]      frac;
      logic            neg;
   } coord_rec_type;

   // One finished GGA line
   typedef struct packed {
      coord_rec_type    lat;
      coord_rec_type    lon;
      logic [SAT_W-1:0] sats;
   } line_rec_type;

   // One result transaction
   typedef struct packed {
      logic signed [LAT_W-1:0] lat;
      logic signed [LON_W-1:0] lon;
      logic [SAT_W-1:0]        sats;
   } result_type;

   // Powers of ten up to one million
   function automatic logic [19:0] pow10(input logic [2:0] k);
      logic [19:0] r;
      case (k)
         3'd0:    r = 20'd1;
         3'd1:    r = 20'd10;
         3'd2:    r = 20'd100;
         3'd3:    r = 20'd1000;
         3'd4:    r = 20'd10000;
         3'd5:    r = 20'd100000;
         default: r = 20'd1000000;
      endcase
      return r;
   endfunction

endpackage

/* design/nmgga_fifo.sv */
module nmgga_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   // DEPTH is a power of two; pointers wrap naturally
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* design/nmgga_front.sv */
module nmgga_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rx_push,
   input  logic [7:0]              rx_byte,
   output logic                    rx_full,
   output logic                    rec_push,
   output nmgga_pkg::line_rec_type rec_data,
   input  logic                    rec_full
);
   import nmgga_pkg::*;

   localparam int T_W = MS_W + 4;
   localparam logic [2:0] FRAC_K = 3'(FRACTION_DIGITS);

   // Field numbers counted in commas
   localparam logic [COMMA_W-1:0] FIELD_LAT  = COMMA_W'(2);
   localparam logic [COMMA_W-1:0] FIELD_NS   = COMMA_W'(3);
   localparam logic [COMMA_W-1:0] FIELD_LON  = COMMA_W'(4);
   localparam logic [COMMA_W-1:0] FIELD_EW   = COMMA_W'(5);
   localparam logic [COMMA_W-1:0] FIELD_SATS = COMMA_W'(7);
   localparam logic [COMMA_W-1:0] COMMA_MAX  = COMMA_W'(LINE_FIELD_LIMIT - 1);

   typedef struct packed {
      logic [6:0]      two;
      logic [9:0]      three;
      logic [MS_W-1:0] scaled;
      logic            point;
      logic            stop;
      logic [2:0]      frac;
      logic [3:0]      len;
      logic            neg;
      logic            dstop;
      logic [7:0]      held0;
      logic [7:0]      held1;
      logic            three_mode;
   } coord_st_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30) && (ch <= 8'h39);
   endfunction

   // Minutes text: whole digits, one point, limited fraction digits
   function automatic coord_st_type minutes_feed(input coord_st_type s, input logic [7:0] ch);
      coord_st_type   r;
      logic [T_W-1:0] t;
      r = s;
      t = ({4'd0, s.scaled} * T_W'(10)) + T_W'(ch[3:0]);
      if (!s.stop) begin
         if (is_digit(ch)) begin
            if (!s.point) begin
               r.scaled = (t > T_W'(100)) ? MS_W'(100) : t[MS_W-1:0];
            end else if (s.frac < FRAC_K) begin
               r.scaled = t[MS_W-1:0];
               r.frac   = s.frac + 3'd1;
            end
         end else if (ch == CH_POINT && !s.point) begin
            r.point = 1'b1;
         end else begin
            r.stop = 1'b1;
         end
      end
      return r;
   endfunction

   // One character of a coordinate field at field position p
   function automatic coord_st_type coord_char(input coord_st_type s, input logic [7:0] ch,
                                               input logic [3:0] p);
      coord_st_type r;
      r = s;
      if (s.len != 4'd15) begin
         r.len = s.len + 4'd1;
      end
      if (p < 4'd3) begin
         if (is_digit(ch) && !s.dstop) begin
            if (p < 4'd2) begin
               r.two = (s.two * 7'd10) + {3'd0, ch[3:0]};
            end
            r.three = (s.three * 10'd10) + {6'd0, ch[3:0]};
         end else begin
            r.dstop = 1'b1;
         end
      end
      if (p == 4'd2) begin
         r.held0 = ch;
      end else if (p == 4'd3) begin
         r.held1 = ch;
      end else if (p == 4'd4) begin
         if (ch == CH_POINT) begin
            r = minutes_feed(minutes_feed(minutes_feed(r, s.held0), s.held1), ch);
         end else begin
            r.three_mode = 1'b1;
            r = minutes_feed(minutes_feed(r, s.held1), ch);
         end
      end else if (p > 4'd4) begin
         r = minutes_feed(r, ch);
      end
      return r;
   endfunction

   function automatic coord_rec_type to_rec(input coord_st_type s);
      coord_rec_type r;
      r.len_ok     = (s.len > 4'd5);
      r.three_mode = s.three_mode;
      r.two        = s.two;
      r.three      = s.three;
      r.scaled     = s.scaled;
      r.frac       = s.frac;
      r.neg        = s.neg;
      return r;
   endfunction

   logic [2:0]         lp_ff, lp_in;
   logic               hok_ff, hok_in;
   logic [COMMA_W-1:0] cc_ff, cc_in;
   logic [3:0]         fp_ff, fp_in;
   coord_st_type       lat_ff, lat_in, lon_ff, lon_in;
   logic [SAT_W-1:0]   sats_ff, sats_in;
   logic               sstop_ff, sstop_in;
   logic               accept, is_term, match;
   logic [9:0]         sat_t;

   assign rx_full = rec_full;
   assign accept  = rx_push && !rec_full;
   assign is_term = (rx_byte == CH_CR) || (rx_byte == CH_LF);
   assign rec_push = accept && is_term && hok_ff && (lp_ff >= 3'd6) && (cc_ff >= FIELD_SATS);
   assign rec_data = '{lat: to_rec(lat_ff), lon: to_rec(lon_ff), sats: sats_ff};
   assign sat_t    = ({3'd0, sats_ff} * 10'd10) + {6'd0, rx_byte[3:0]};

   // Header character check
   always_comb begin
      unique case (lp_ff)
         3'd0:    match = (rx_byte == CH_DOLLAR);
         3'd1:    match = (rx_byte == CH_G);
         3'd2:    match = (rx_byte == CH_P) || (rx_byte == CH_N);
         3'd3:    match = (rx_byte == CH_G);
         3'd4:    match = (rx_byte == CH_G);
         default: match = (rx_byte == CH_A);
      endcase
   end

   // Per-byte line state update
   always_comb begin
      lp_in    = lp_ff;
      hok_in   = hok_ff;
      cc_in    = cc_ff;
      fp_in    = fp_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      sats_in  = sats_ff;
      sstop_in = sstop_ff;
      if (is_term) begin
         lp_in    = '0;
         hok_in   = 1'b1;
         cc_in    = '0;
         fp_in    = '0;
         lat_in   = '0;
         lon_in   = '0;
         sats_in  = '0;
         sstop_in = 1'b0;
      end else begin
         if (lp_ff < 3'd6) begin
            hok_in = hok_ff && match;
            lp_in  = lp_ff + 3'd1;
         end
         if (rx_byte == CH_COMMA) begin
            if (cc_ff < COMMA_MAX) begin
               cc_in = cc_ff + 1'b1;
            end
            fp_in = '0;
         end else begin
            case (cc_ff)
               FIELD_LAT: lat_in = coord_char(lat_ff, rx_byte, fp_ff);
               FIELD_LON: lon_in = coord_char(lon_ff, rx_byte, fp_ff);
               FIELD_NS: begin
                  if (fp_ff == 4'd0) begin
                     lat_in.neg = (rx_byte == CH_S) || (rx_byte == CH_W);
                  end
               end
               FIELD_EW: begin
                  if (fp_ff == 4'd0) begin
                     lon_in.neg = (rx_byte == CH_S) || (rx_byte == CH_W);
                  end
               end
               FIELD_SATS: begin
                  if (!sstop_ff && is_digit(rx_byte)) begin
                     sats_in = (sat_t > 10'd99) ? 7'd99 : sat_t[SAT_W-1:0];
                  end else begin
                     sstop_in = 1'b1;
                  end
               end
               default: ;
            endcase
            if (fp_ff != 4'd15) begin
               fp_in = fp_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff    <= '0;
         hok_ff   <= 1'b1;
         cc_ff    <= '0;
         fp_ff    <= '0;
         lat_ff   <= '0;
         lon_ff   <= '0;
         sats_ff  <= '0;
         sstop_ff <= 1'b0;
      end else if (accept) begin
         lp_ff    <= lp_in;
         hok_ff   <= hok_in;
         cc_ff    <= cc_in;
         fp_ff    <= fp_in;
         lat_ff   <= lat_in;
         lon_ff   <= lon_in;
         sats_ff  <= sats_in;
         sstop_ff <= sstop_in;
      end
   end

endmodule

/* design/nmgga_back.sv */
module nmgga_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rec_empty,
   output logic                    rec_pop,
   input  nmgga_pkg::line_rec_type rec_data,
   output logic                    res_push,
   output nmgga_pkg::result_type   res_data,
   input  logic                    res_full
);
   import nmgga_pkg::*;

   localparam logic [2:0]      FRAC_K = 3'(FRACTION_DIGITS);
   localparam logic [MR_W-1:0] MS_CAP = MR_W'(100 * 10**FRACTION_DIGITS - 1);
   localparam logic [X_W-1:0]  POW_HI = X_W'(10**(6 - FRACTION_DIGITS));
   localparam int              P_W    = X_W + RECIP_W;

   logic adv;
   logic v1_ff, v2_ff, v3_ff;
   logic [SAT_W-1:0] sats1_ff, sats2_ff, sats3_ff;
   coord_rec_type    crd [2];
   logic [MAG_W-1:0] mag [2];

   assign adv      = !res_full;
   assign rec_pop  = adv && !rec_empty;
   assign res_push = v3_ff && adv;
   assign crd[0]   = rec_data.lat;
   assign crd[1]   = rec_data.lon;

   // Valid and shared fields follow the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= rec_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sats1_ff <= rec_data.sats;
         sats2_ff <= sats1_ff;
         sats3_ff <= sats2_ff;
      end
   end

   // One lane per coordinate: scale minutes, divide by 60, add degrees
   for (genvar i = 0; i < 2; i++) begin : g_lane
      logic [MR_W-1:0]  ms1_ff, ms1_in;
      logic [DEG_W-1:0] deg1_ff, deg2_ff, deg3_ff, deg1_in;
      logic [X_W-1:0]   x2_ff, x2_in;
      logic [P_W-1:0]   p3_ff, p3_in;
      logic [MR_W-1:0]  msc;
      logic [2:0]       k;
      logic [9:0]       deg;
      logic [1:0]       ok1_ff, ok2_ff, ok3_ff;

      // Stage 1: minutes to full fraction scale, degrees times one million
      always_comb begin
         k       = (crd[i].frac > FRAC_K) ? FRAC_K : crd[i].frac;
         deg     = crd[i].three_mode ? crd[i].three : {3'd0, crd[i].two};
         ms1_in  = MR_W'(crd[i].scaled) * MR_W'(pow10(FRAC_K - k));
         deg1_in = DEG_W'(deg) * DEG_W'(1000000);
      end

      // Stage 2: clamp below 100 minutes, scale to millionths
      always_comb begin
         msc   = (ms1_ff > MS_CAP) ? MS_CAP : ms1_ff;
         x2_in = X_W'(msc) * POW_HI;
      end

      // Stage 3: reciprocal multiply for the divide by 60
      assign p3_in = P_W'(x2_ff) * P_W'(RECIP_60);

      // Stage 4: quotient plus degrees, gated by field length
      assign mag[i] = ok3_ff[0] ?
                      (MAG_W'(deg3_ff) + MAG_W'(p3_ff[P_W-1:RECIP_SHIFT])) : '0;

      // ok bit 0 is field length, bit 1 is hemisphere
      always_ff @(posedge clock) begin
         if (adv) begin
            ms1_ff  <= ms1_in;
            deg1_ff <= deg1_in;
            ok1_ff  <= {crd[i].neg, crd[i].len_ok};
            x2_ff   <= x2_in;
            deg2_ff <= deg1_ff;
            ok2_ff  <= ok1_ff;
            p3_ff   <= p3_in;
            deg3_ff <= deg2_ff;
            ok3_ff  <= ok2_ff;
         end
      end
   end

   // Latitude clamp, signs of both coordinates and the result fields
   logic [MAG_W-1:0] lat_mag, lat_sgn, lon_sgn;

   always_comb begin
      lat_mag       = (mag[0] > LAT_LIMIT) ? LAT_LIMIT : mag[0];
      lat_sgn       = g_lane[0].ok3_ff[1] ? (MAG_W'(0) - lat_mag) : lat_mag;
      lon_sgn       = g_lane[1].ok3_ff[1] ? (MAG_W'(0) - mag[1]) : mag[1];
      res_data.lat  = lat_sgn[LAT_W-1:0];
      res_data.lon  = lon_sgn[LON_W-1:0];
      res_data.sats = sats3_ff;
   end

endmodule

/* design/nmea_gga_position_parser.sv */
// Channel    | Ports                                        | Moves
// -----------+----------------------------------------------+--------------------------
// request    | req_push, req_full, req_rx_byte              | one NMEA character
// response   | rsp_pop, rsp_empty, rsp_latitude_micro,      | one GGA position
//            | rsp_longitude_micro, rsp_satellite_count     |
//
// A character is taken per cycle while req_full is low; line state updates in one step.
// A result reaches the response queue once its CR or LF has passed the line queue,
// the three multiply stages of the back end and the queue write.
// Reset is synchronous, active high, and empties both queues and clears the line.
// A full response queue stalls the back end; a full line queue then raises req_full.
module nmea_gga_position_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic signed [nmgga_pkg::LAT_W-1:0]   rsp_latitude_micro,
   output logic signed [nmgga_pkg::LON_W-1:0]   rsp_longitude_micro,
   output logic [nmgga_pkg::SAT_W-1:0]          rsp_satellite_count
);
   import nmgga_pkg::*;

   line_rec_type rec_in, rec_out;
   result_type   res_in, res_out;
   logic         rec_push, rec_full, rec_pop, rec_empty;
   logic         res_push, res_full;

   nmgga_front u_front (
      .clock    (clock),
      .reset    (reset),
      .rx_push  (req_push),
      .rx_byte  (req_rx_byte),
      .rx_full  (req_full),
      .rec_push (rec_push),
      .rec_data (rec_in),
      .rec_full (rec_full)
   );

   // Finished lines waiting for arithmetic
   nmgga_fifo #(
      .WIDTH ($bits(line_rec_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_line_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_out),
      .empty     (rec_empty)
   );

   nmgga_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (rec_empty),
      .rec_pop   (rec_pop),
      .rec_data  (rec_out),
      .res_push  (res_push),
      .res_data  (res_in),
      .res_full  (res_full)
   );

   // Results waiting to be taken
   nmgga_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_latitude_micro  = res_out.lat;
   assign rsp_longitude_micro = res_out.lon;
   assign rsp_satellite_count = res_out.sats;

endmodule

/* design/nmgga_checker.sv */
`include "assert_macros.svh"

module nmgga_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_push,
   input logic                                 req_full,
   input logic [7:0]                           req_rx_byte,
   input logic                                 rsp_pop,
   input logic                                 rsp_empty,
   input logic signed [nmgga_pkg::LAT_W-1:0]   rsp_latitude_micro,
   input logic signed [nmgga_pkg::LON_W-1:0]   rsp_longitude_micro,
   input logic [nmgga_pkg::SAT_W-1:0]          rsp_satellite_count
);
   // Satellite count saturates
   `ASSERT_ALWAYS(a_sat_range, clock, reset, !rsp_empty |-> rsp_satellite_count <= 7'd99, "satellite count above 99")

   // Latitude clamp
   `ASSERT_ALWAYS(a_lat_range, clock, reset, !rsp_empty |-> (rsp_latitude_micro <= 28'sd101666666 && rsp_latitude_micro >= -28'sd101666666), "latitude out of range")

   // A waiting result holds until taken
   `ASSERT_AT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_latitude_micro) && $stable(rsp_longitude_micro) && $stable(rsp_satellite_count)), "waiting result changed")

   // Queues come out of reset empty
   `ASSERT_AT(a_reset_empty, clock, reset, $past(reset) |-> (rsp_empty && !req_full), "queues not empty after reset")

endmodule

bind nmea_gga_position_parser nmgga_checker u_checker (.*);

/* bench/tb_nmea_gga_position_parser.sv */
module tb_nmea_gga_position_parser;
   import nmgga_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int STREAM_BYTES = 1200;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [7:0]              req_rx_byte = 8'h00;
   logic                    rsp_pop = 1'b0;
   logic                    rsp_empty;
   logic signed [LAT_W-1:0] rsp_latitude_micro;
   logic signed [LON_W-1:0] rsp_longitude_micro;
   logic [SAT_W-1:0]        rsp_satellite_count;

   nmea_gga_position_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_latitude_micro  (rsp_latitude_micro),
      .rsp_longitude_micro (rsp_longitude_micro),
      .rsp_satellite_count (rsp_satellite_count)
   );

   always #2 clock = ~clock;

   result_type expected_positions[$];
   int         mismatches     = 0;
   int         cycle_count    = 0;
   int         bytes_sent     = 0;
   int         positions_seen = 0;
   int         burst_left     = 0;

   // Line parser state mirrored by the predictor
   int          hdr_pos;
   bit          hdr_ok;
   int          commas;
   int          fld_pos;
   int unsigned deg2[2];
   int unsigned deg3[2];
   int unsigned min_acc[2];
   bit          min_point[2];
   bit          min_stop[2];
   int          min_frac[2];
   int          coord_len[2];
   bit          hemi_neg[2];
   bit          deg_stop[2];
   logic [7:0]  held[2][2];
   bit          wide_deg[2];
   int unsigned sat_acc;
   bit          sat_stop;

   function automatic bit is_num(logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic void clear_line_state();
      hdr_pos = 0;
      hdr_ok  = 1'b1;
      commas  = 0;
      fld_pos = 0;
      for (int c = 0; c < 2; c++) begin
         deg2[c] = 0;  deg3[c] = 0;  min_acc[c] = 0;
         min_point[c] = 0;  min_stop[c] = 0;  min_frac[c] = 0;
         coord_len[c] = 0;  hemi_neg[c] = 0;  deg_stop[c] = 0;
         held[c][0] = 8'h00;  held[c][1] = 8'h00;  wide_deg[c] = 0;
      end
      sat_acc  = 0;
      sat_stop = 1'b0;
   endfunction

   // Minutes text: whole digits (clamped at 100), one point, limited fraction
   function automatic void feed_minutes(int c, logic [7:0] ch);
      if (min_stop[c])
         return;
      if (is_num(ch)) begin
         if (!min_point[c]) begin
            min_acc[c] = min_acc[c] * 10 + (ch - "0");
            if (min_acc[c] > 100)
               min_acc[c] = 100;
         end else if (min_frac[c] < FRACTION_DIGITS) begin
            min_acc[c] = min_acc[c] * 10 + (ch - "0");
            min_frac[c]++;
         end
      end else if (ch == CH_POINT && !min_point[c]) begin
         min_point[c] = 1'b1;
      end else begin
         min_stop[c] = 1'b1;
      end
   endfunction

   function automatic void coord_byte(int c, logic [7:0] ch, int p);
      if (coord_len[c] < 15)
         coord_len[c]++;
      if (p < 3) begin
         if (is_num(ch) && !deg_stop[c]) begin
            if (p < 2)
               deg2[c] = deg2[c] * 10 + (ch - "0");
            deg3[c] = deg3[c] * 10 + (ch - "0");
         end else begin
            deg_stop[c] = 1'b1;
         end
      end
      if (p == 2 || p == 3) begin
         held[c][p-2] = ch;
      end else if (p == 4) begin
         if (ch == CH_POINT) begin
            feed_minutes(c, held[c][0]);
            feed_minutes(c, held[c][1]);
            feed_minutes(c, ch);
         end else begin
            wide_deg[c] = 1'b1;
            feed_minutes(c, held[c][1]);
            feed_minutes(c, ch);
         end
      end else if (p > 4) begin
         feed_minutes(c, ch);
      end
   endfunction

   // Magnitude in micro-degrees of one coordinate
   function automatic longint coord_micro(int c);
      longint deg, ms, scale;
      if (coord_len[c] <= 5)
         return 0;
      deg   = wide_deg[c] ? deg3[c] : deg2[c];
      scale = 1;
      for (int i = min_frac[c]; i < FRACTION_DIGITS; i++)
         scale = scale * 10;
      ms = longint'(min_acc[c]) * scale;
      if (ms > 64'd9999999)
         ms = 9999999;
      return deg * 1000000 + ms * 10 / 60;
   endfunction

   // One character in; returns 1 when a line end yields a position
   function automatic bit gga_step(input logic [7:0] ch, output result_type pos);
      int     p;
      bit     hit;
      longint lat, lon;
      p   = fld_pos;
      pos = '0;
      if (ch == CH_CR || ch == CH_LF) begin
         hit = hdr_ok && hdr_pos >= 6 && commas >= 7;
         if (hit) begin
            lat = coord_micro(0);
            lon = coord_micro(1);
            if (lat > longint'(LAT_LIMIT))
               lat = LAT_LIMIT;
            pos.lat  = LAT_W'(hemi_neg[0] ? -lat : lat);
            pos.lon  = LON_W'(hemi_neg[1] ? -lon : lon);
            pos.sats = SAT_W'(sat_acc);
         end
         clear_line_state();
         return hit;
      end
      if (hdr_pos < 6) begin
         case (hdr_pos)
            0: if (ch != CH_DOLLAR) hdr_ok = 1'b0;
            1, 3, 4: if (ch != CH_G) hdr_ok = 1'b0;
            2: if (ch != CH_P && ch != CH_N) hdr_ok = 1'b0;
            default: if (ch != CH_A) hdr_ok = 1'b0;
         endcase
         hdr_pos++;
      end
      if (ch == CH_COMMA) begin
         if (commas < LINE_FIELD_LIMIT - 1)
            commas++;
         fld_pos = 0;
         return 1'b0;
      end
      case (commas)
         2: coord_byte(0, ch, p);
         4: coord_byte(1, ch, p);
         3: if (p == 0) hemi_neg[0] = (ch == CH_S || ch == CH_W);
         5: if (p == 0) hemi_neg[1] = (ch == CH_S || ch == CH_W);
         7: begin
            if (!sat_stop && is_num(ch)) begin
               sat_acc = sat_acc * 10 + (ch - "0");
               if (sat_acc > 99)
                  sat_acc = 99;
            end else begin
               sat_stop = 1'b1;
            end
         end
         default: ;
      endcase
      if (fld_pos < 15)
         fld_pos++;
      return 1'b0;
   endfunction

   // Send one character, honoring bursts and gaps of the sender
   task automatic send_char(logic [7:0] ch);
      result_type pos;
      int         gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_push    <= 1'b1;
      req_rx_byte <= ch;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
      if (gga_step(ch, pos))
         expected_positions.push_back(pos);
   endtask

   task automatic send_line(string s, logic [7:0] term);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
      send_char(term);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_positions.size() > 0)
         @(posedge clock);
   endtask

   function automatic string rand_digits(int n);
      string s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string rand_coord();
      string s;
      s = rand_digits($urandom_range(0, 5) == 0 ? 3 : 2);
      s = {s, rand_digits($urandom_range(0, 6) == 0 ? $urandom_range(0, 4) : 2)};
      if ($urandom_range(0, 7) != 0)
         s = {s, ".", rand_digits($urandom_range(0, 9))};
      if ($urandom_range(0, 9) == 0)
         s = {s, string'(byte'($urandom_range(32, 126)))};
      return $urandom_range(0, 15) == 0 ? "" : s;
   endfunction

   function automatic string rand_hemi();
      case ($urandom_range(0, 4))
         0: return "N";
         1: return "S";
         2: return "E";
         3: return "W";
         default: return $urandom_range(0, 1) ? "" : string'(byte'($urandom_range(32, 126)));
      endcase
   endfunction

   // Well-formed GGA line with random content, sometimes damaged
   function automatic string rand_gga();
      string s;
      int    n;
      s = {$urandom_range(0, 1) ? "$GP" : "$GN", "GGA,", rand_digits(6), ",",
           rand_coord(), ",", rand_hemi(), ",", rand_coord(), ",", rand_hemi(), ",",
           rand_digits(1), ",", rand_digits($urandom_range(0, 3))};
      n = $urandom_range(0, 14);
      for (int i = 0; i < n; i++)
         s = {s, ",", rand_digits($urandom_range(0, 4))};
      if ($urandom_range(0, 9) == 0 && s.len() > 0)
         s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
      return s;
   endfunction

   task automatic test_reference_sentences();
      send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", CH_CR);
      send_char(CH_LF);
      send_line("$GNGGA,0,0000.00000,S,00000.00000,W,0,00", CH_LF);
      send_line("$GPGGA,1,8959.99999,N,17959.99999,E,1,12", CH_CR);
      send_line("$GPGGA,1,9999.99999999,S,99999.999999,W,1,99", CH_CR);
      send_line("$GNGGA,1,12345.6789,S,1234,W,1,123,", CH_CR);
      send_line("$GPGGA,1,123456789012345678,N,4A07.0,E,1,7x,", CH_LF);
      send_line("$GPGGA,1,4807.0.3,X,0113X.5,W,1,,", CH_CR);
      send_line({"$GPGGA,1,48", string'(byte'(8'hFF)), "7.0,S,01131,W,1,5"}, CH_CR);
   endtask

   task automatic test_rejected_lines();
      send_line("", CH_CR);
      send_line("$GPG", CH_CR);
      send_line("$GPRMC,1,4807.0,N,01131.0,E,1,08", CH_LF);
      send_line("$GLGGA,1,4807.0,N,01131.0,E,1,08", CH_LF);
      send_line("$GPGGA,1,4807.0,N,01131.0,E,1", CH_CR);
      send_line({"$GPGGA,", string'(byte'(8'h01)), ",4807.0,N,,,,,,,,,,,,,,,,,,,,,,,3"}, CH_CR);
      send_line({"$GPGGA", string'(byte'(8'h80)), ",,,,,,,,"}, CH_LF);
   endtask

   task automatic test_drain_pause();
      send_line("$GNGGA,1,5130.12345,N,00007.5,W,1,9", CH_CR);
      wait_drained();
      send_line("$GPGGA,1,3352.1,S,15112.9,E,1,10", CH_LF);
   endtask

   task automatic test_random_stream();
      int start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < STREAM_BYTES) begin
         if ($urandom_range(0, 9) < 8) begin
            send_line(rand_gga(), $urandom_range(0, 1) ? CH_CR : CH_LF);
         end else begin
            repeat ($urandom_range(0, 20))
               send_char($urandom_range(0, 255));
         end
      end
      send_char(CH_LF);
   endtask

   // Result receiver with its own stall pattern, and the checker
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         case ((cycle_count / 97) % 3)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= $urandom_range(0, 1);
            default: rsp_pop <= (cycle_count % 5) == 0;
         endcase
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_positions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected position transaction: lat %0d lon %0d sats %0d",
                           rsp_latitude_micro, rsp_longitude_micro, rsp_satellite_count);
            end else begin
               result_type want;
               want = expected_positions.pop_front();
               positions_seen++;
               if (rsp_latitude_micro !== want.lat || rsp_longitude_micro !== want.lon ||
                   rsp_satellite_count !== want.sats) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("position mismatch: exp %0d %0d %0d got %0d %0d %0d",
                              want.lat, want.lon, want.sats, rsp_latitude_micro,
                              rsp_longitude_micro, rsp_satellite_count);
               end
            end
         end
      end
   end

   initial begin
      clear_line_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reference_sentences();
      test_rejected_lines();
      test_drain_pause();
      test_random_stream();
      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatches == 0 && expected_positions.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
